/* rtl/rv32_execute_alu_branch_unit_macros.svh */
// Assertion macros for the RV32I execute ALU and branch unit.
// Used by the top level; expects a clock named i_clk and a reset named i_rst_n.
`ifndef RV32_EXECUTE_ALU_BRANCH_UNIT_MACROS_SVH
`define RV32_EXECUTE_ALU_BRANCH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RV32EXAB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RV32EXAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rv32exab_pkg.sv */
// Types and constants shared by the RV32I execute ALU and branch unit.
// No dependencies.
package rv32exab_pkg;

    localparam int unsigned XLEN = 32;

    typedef logic [XLEN-1:0] t_word;
    typedef logic [2:0]      t_funct3;
    typedef logic [6:0]      t_funct7;
    typedef logic [4:0]      t_reg_idx;

    typedef enum logic [2:0] {
        CLS_RTYPE  = 3'd0,
        CLS_ITYPE  = 3'd1,
        CLS_LOAD   = 3'd2,
        CLS_STORE  = 3'd3,
        CLS_BRANCH = 3'd4,
        CLS_JAL    = 3'd5,
        CLS_JALR   = 3'd6,
        CLS_LUI    = 3'd7
    } t_op_class;

    // ALU operations selected by funct3.
    localparam t_funct3 F3_ADD  = 3'd0;
    localparam t_funct3 F3_SLL  = 3'd1;
    localparam t_funct3 F3_SLT  = 3'd2;
    localparam t_funct3 F3_XOR  = 3'd4;
    localparam t_funct3 F3_SR   = 3'd5;
    localparam t_funct3 F3_OR   = 3'd6;
    localparam t_funct3 F3_AND  = 3'd7;

    // Branch conditions selected by funct3.
    localparam t_funct3 F3_BEQ  = 3'd0;
    localparam t_funct3 F3_BNE  = 3'd1;
    localparam t_funct3 F3_BLT  = 3'd4;
    localparam t_funct3 F3_BGE  = 3'd5;

    localparam t_funct7 F7_ALT      = 7'h20;
    localparam t_word   LINK_OFFSET = 32'd4;

    typedef struct packed {
        t_op_class op_class;
        t_funct3   funct3;
        t_funct7   funct7;
        t_word     operand_a;
        t_word     operand_b;
        t_word     immediate;
        t_reg_idx  dest_reg;
        t_word     instr_addr;
    } t_in_item;

    typedef struct packed {
        t_word    result;
        logic     write_enable;
        t_reg_idx write_reg;
        logic     branch_taken;
        t_word    branch_target;
        logic     dropped;
    } t_out_item;

endpackage

/* rtl/rv32exab_if.sv */
// Valid/ready channel interfaces for the instruction and result beats.
// Depends on rv32exab_pkg.
interface rv32exab_in_if
    import rv32exab_pkg::*;
;
    logic      valid;
    logic      ready;
    t_op_class op_class;
    t_funct3   funct3;
    t_funct7   funct7;
    t_word     operand_a;
    t_word     operand_b;
    t_word     immediate;
    t_reg_idx  dest_reg;
    t_word     instr_addr;

    modport source (
        output valid, op_class, funct3, funct7, operand_a, operand_b,
               immediate, dest_reg, instr_addr,
        input  ready
    );
    modport sink (
        input  valid, op_class, funct3, funct7, operand_a, operand_b,
               immediate, dest_reg, instr_addr,
        output ready
    );
endinterface

interface rv32exab_out_if
    import rv32exab_pkg::*;
;
    logic     valid;
    logic     ready;
    t_word    result;
    logic     write_enable;
    t_reg_idx write_reg;
    logic     branch_taken;
    t_word    branch_target;
    logic     dropped;

    modport source (
        output valid, result, write_enable, write_reg, branch_taken,
               branch_target, dropped,
        input  ready
    );
    modport sink (
        input  valid, result, write_enable, write_reg, branch_taken,
               branch_target, dropped,
        output ready
    );
endinterface

/* rtl/rv32exab_core.sv */
// Combinational ALU, branch compare and writeback control for one instruction.
// Depends on rv32exab_pkg.
module rv32exab_core
    import rv32exab_pkg::*;
(
    input  t_in_item  i_item,
    output t_out_item o_item
);

    t_word    w_alu;
    t_word    w_link;
    logic     w_alt_sub;
    logic     w_alt_sra;
    logic     w_cond;
    logic     w_writes;
    logic [4:0] w_sh;
    t_word    w_res;
    logic     w_drop;
    logic     w_is_branch;

    assign w_sh = i_item.operand_b[4:0];

    always_comb begin
        w_alt_sub = 1'b0;
        w_alt_sra = 1'b0;
        if (i_item.op_class == CLS_RTYPE) begin
            w_alt_sub = (i_item.funct7 == F7_ALT);
            w_alt_sra = (i_item.funct7 == F7_ALT);
        end else begin
            // Immediate shifts carry their funct7 in the upper immediate bits.
            w_alt_sra = (i_item.operand_b[11:5] == F7_ALT);
        end
    end

    always_comb begin
        unique case (i_item.funct3)
            F3_ADD:  w_alu = w_alt_sub ? (i_item.operand_a - i_item.operand_b)
                                       : (i_item.operand_a + i_item.operand_b);
            F3_SLL:  w_alu = i_item.operand_a << w_sh;
            F3_SLT:  w_alu = {{(XLEN-1){1'b0}},
                              ($signed(i_item.operand_a) < $signed(i_item.operand_b))};
            F3_XOR:  w_alu = i_item.operand_a ^ i_item.operand_b;
            F3_SR:   w_alu = w_alt_sra ? t_word'($signed(i_item.operand_a) >>> w_sh)
                                       : (i_item.operand_a >> w_sh);
            F3_OR:   w_alu = i_item.operand_a | i_item.operand_b;
            F3_AND:  w_alu = i_item.operand_a & i_item.operand_b;
            default: w_alu = '0;
        endcase
    end

    always_comb begin
        unique case (i_item.funct3)
            F3_BEQ:  w_cond = (i_item.operand_a == i_item.operand_b);
            F3_BNE:  w_cond = (i_item.operand_a != i_item.operand_b);
            F3_BLT:  w_cond = ($signed(i_item.operand_a) < $signed(i_item.operand_b));
            F3_BGE:  w_cond = ($signed(i_item.operand_a) >= $signed(i_item.operand_b));
            default: w_cond = 1'b0;
        endcase
    end

    assign w_link = i_item.instr_addr + LINK_OFFSET;

    always_comb begin
        w_res       = '0;
        w_writes    = 1'b0;
        w_drop      = 1'b0;
        w_is_branch = 1'b0;
        unique case (i_item.op_class)
            CLS_RTYPE, CLS_ITYPE: begin
                w_res    = w_alu;
                w_writes = 1'b1;
            end
            CLS_LOAD, CLS_STORE: begin
                w_drop = 1'b1;
            end
            CLS_BRANCH: begin
                w_is_branch = 1'b1;
            end
            CLS_JAL, CLS_JALR: begin
                w_res    = w_link;
                w_writes = 1'b1;
            end
            CLS_LUI: begin
                w_res    = i_item.immediate;
                w_writes = 1'b1;
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // A write to x0 is suppressed, but the computed value is still reported.
    always_comb begin
        o_item.result        = w_res;
        o_item.write_enable  = w_writes && (i_item.dest_reg != '0);
        o_item.write_reg     = o_item.write_enable ? i_item.dest_reg : '0;
        o_item.branch_taken  = w_is_branch && w_cond;
        o_item.branch_target = o_item.branch_taken
                             ? (i_item.instr_addr + i_item.immediate) : '0;
        o_item.dropped       = w_drop;
    end

endmodule

/* rtl/rv32_execute_alu_branch_unit.sv */
// RV32I execute stage: ALU, branch compare and writeback control.
// An accepted instruction beat passes through the input register, then the result
// register, to its result beat; throughput: one beat per cycle while the result side is ready.
// A register holds while the stage after it is full and not taken; nothing iterates.
// Reset (i_rst_n low, synchronous) empties both stages; payload is not cleared.
// Depends on rv32exab_pkg, rv32exab_if, rv32exab_core and the macros header.
`include "rv32_execute_alu_branch_unit_macros.svh"

module rv32_execute_alu_branch_unit
    import rv32exab_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rv32exab_in_if.sink           i_in,
    rv32exab_out_if.source        o_out
);

    logic      r_s1_valid;
    logic      n_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item w_calc;
    logic      w_out_free;
    logic      w_s1_adv;
    logic      w_in_acc;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign i_in.ready = !r_s1_valid || w_out_free;
    assign w_in_acc   = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (w_in_acc) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_valid = 1'b0;
        end
        if (w_s1_adv) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1.op_class   <= t_op_class'(i_in.op_class);
            r_s1.funct3     <= i_in.funct3;
            r_s1.funct7     <= i_in.funct7;
            r_s1.operand_a  <= i_in.operand_a;
            r_s1.operand_b  <= i_in.operand_b;
            r_s1.immediate  <= i_in.immediate;
            r_s1.dest_reg   <= i_in.dest_reg;
            r_s1.instr_addr <= i_in.instr_addr;
        end
        if (w_s1_adv) begin
            r_out <= w_calc;
        end
    end

    rv32exab_core u_core (
        .i_item (r_s1),
        .o_item (w_calc)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.result        = r_out.result;
    assign o_out.write_enable  = r_out.write_enable;
    assign o_out.write_reg     = r_out.write_reg;
    assign o_out.branch_taken  = r_out.branch_taken;
    assign o_out.branch_target = r_out.branch_target;
    assign o_out.dropped       = r_out.dropped;

    `RV32EXAB_ASSERT_SAME(a_we_not_x0, o_out.valid && o_out.write_enable,
        o_out.write_reg != '0, "register write targets x0")
    `RV32EXAB_ASSERT_SAME(a_branch_excl, o_out.valid && o_out.branch_taken,
        !o_out.write_enable && !o_out.dropped, "taken branch also writes or drops")
    `RV32EXAB_ASSERT_NEXT(a_s1_kept, r_s1_valid && r_out_valid && !o_out.ready,
        r_s1_valid, "stalled instruction lost from input stage")

endmodule

/* sim/rv32exab_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the RV32I execute ALU and branch unit: watches the instruction
// and result channels, predicts each result and compares it field by field.
// Depends on rv32exab_pkg and rv32exab_if.
module rv32exab_checker
    import rv32exab_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    rv32exab_in_if  i_instr,
    rv32exab_out_if i_result,
    output int     o_pending,
    output int     o_mismatches,
    output int     o_checked,
    output int     o_taken
);

    t_out_item predicted_results[$];
    int        mismatch_count = 0;
    int        checked_count  = 0;
    int        taken_count    = 0;

    function automatic t_word alu_value(t_funct3 f3, t_word a, t_word b,
                                        logic sub, logic arith);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            F3_ADD:  return sub ? a - b : a + b;
            F3_SLL:  return a << sh;
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return arith ? t_word'($signed(a) >>> sh) : a >> sh;
            F3_OR:   return a | b;
            F3_AND:  return a & b;
            // The unsigned compare is not implemented and reads as zero.
            default: return '0;
        endcase
    endfunction

    function automatic logic branch_holds(t_funct3 f3, t_word a, t_word b);
        case (f3)
            F3_BEQ:  return a == b;
            F3_BNE:  return a != b;
            F3_BLT:  return $signed(a) < $signed(b);
            F3_BGE:  return $signed(a) >= $signed(b);
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_out_item execute_instr(t_in_item ins);
        t_out_item r;
        logic      writes;
        r      = '0;
        writes = 1'b0;
        case (ins.op_class)
            CLS_RTYPE: begin
                r.result = alu_value(ins.funct3, ins.operand_a, ins.operand_b,
                                     ins.funct7 == F7_ALT, ins.funct7 == F7_ALT);
                writes   = 1'b1;
            end
            CLS_ITYPE: begin
                // For immediates the shift kind sits in the upper immediate bits.
                r.result = alu_value(ins.funct3, ins.operand_a, ins.operand_b, 1'b0,
                                     ins.operand_b[11:5] == F7_ALT);
                writes   = 1'b1;
            end
            CLS_LOAD, CLS_STORE: begin
                r.dropped = 1'b1;
            end
            CLS_BRANCH: begin
                r.branch_taken = branch_holds(ins.funct3, ins.operand_a, ins.operand_b);
                if (r.branch_taken) begin
                    r.branch_target = ins.instr_addr + ins.immediate;
                end
            end
            CLS_JAL, CLS_JALR: begin
                r.result = ins.instr_addr + LINK_OFFSET;
                writes   = 1'b1;
            end
            default: begin
                r.result = ins.immediate;
                writes   = 1'b1;
            end
        endcase
        // A write to x0 is suppressed, but the computed value is still shown.
        if (ins.dest_reg == '0) begin
            writes = 1'b0;
        end
        r.write_enable = writes;
        r.write_reg    = writes ? ins.dest_reg : '0;
        return r;
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_in_item  ins;
        t_out_item want;
        if (i_rst_n) begin
            if (i_instr.valid && i_instr.ready) begin
                ins.op_class   = i_instr.op_class;
                ins.funct3     = i_instr.funct3;
                ins.funct7     = i_instr.funct7;
                ins.operand_a  = i_instr.operand_a;
                ins.operand_b  = i_instr.operand_b;
                ins.immediate  = i_instr.immediate;
                ins.dest_reg   = i_instr.dest_reg;
                ins.instr_addr = i_instr.instr_addr;
                predicted_results.push_back(execute_instr(ins));
            end
            if (i_result.valid && i_result.ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result beat with no instruction outstanding");
                    mismatch_count++;
                end else begin
                    want = predicted_results.pop_front();
                    checked_count++;
                    if (want.branch_taken) begin
                        taken_count++;
                    end
                    mismatch_count += field_diff("result", want.result, i_result.result);
                    mismatch_count += field_diff("write_enable", 32'(want.write_enable),
                                                 32'(i_result.write_enable));
                    mismatch_count += field_diff("write_reg", 32'(want.write_reg),
                                                 32'(i_result.write_reg));
                    mismatch_count += field_diff("branch_taken", 32'(want.branch_taken),
                                                 32'(i_result.branch_taken));
                    mismatch_count += field_diff("branch_target", want.branch_target,
                                                 i_result.branch_target);
                    mismatch_count += field_diff("dropped", 32'(want.dropped),
                                                 32'(i_result.dropped));
                end
            end
        end
        o_pending    <= predicted_results.size();
        o_mismatches <= mismatch_count;
        o_checked    <= checked_count;
        o_taken      <= taken_count;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Top of the execute unit testbench: clock, reset, instruction stimulus with
// random idling on both channels, and the verdict.
// Depends on rv32exab_pkg, rv32exab_if, rv32exab_checker and the unit itself.
module testbench;
    import rv32exab_pkg::*;

    localparam int N_RANDOM    = 2000;
    localparam int QUIET_TAIL  = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 16;

    // funct3 values with no operation behind them in this unit.
    localparam t_funct3 F3_SLTU      = 3'd3;
    localparam t_funct3 F3_BR_NONE   = 3'd2;
    localparam t_funct3 F3_BGEU      = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   idle_pct    = 20;
    logic quiet       = 1'b0;
    int   sent_count  = 0;
    int   pending, mismatches, checked, taken;

    rv32exab_in_if  instr_ch ();
    rv32exab_out_if result_ch ();

    rv32_execute_alu_branch_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    rv32exab_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr      (instr_ch),
        .i_result     (result_ch),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked),
        .o_taken      (taken)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_in_item make_instr(t_op_class cls, t_funct3 f3, t_funct7 f7,
                                            t_word a, t_word b, t_word imm,
                                            t_reg_idx rd, t_word pc);
        t_in_item ins;
        ins.op_class   = cls;
        ins.funct3     = f3;
        ins.funct7     = f7;
        ins.operand_a  = a;
        ins.operand_b  = b;
        ins.immediate  = imm;
        ins.dest_reg   = rd;
        ins.instr_addr = pc;
        return ins;
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            4:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item random_instr();
        t_in_item ins;
        ins.op_class   = t_op_class'($urandom_range(0, 7));
        ins.funct3     = t_funct3'($urandom_range(0, 7));
        ins.funct7     = t_funct7'($urandom_range(0, 127));
        ins.operand_a  = pick_word();
        ins.operand_b  = pick_word();
        ins.immediate  = $urandom_range(0, 1) ? pick_word() : t_word'($urandom());
        ins.dest_reg   = ($urandom_range(0, 9) == 0) ? '0 : t_reg_idx'($urandom_range(1, 31));
        ins.instr_addr = $urandom();
        case (ins.op_class)
            CLS_RTYPE: begin
                if ($urandom_range(0, 1)) begin
                    ins.funct7 = F7_ALT;
                end
            end
            CLS_ITYPE: begin
                if (ins.funct3 == F3_SR && $urandom_range(0, 1)) begin
                    ins.operand_b[11:5] = F7_ALT;
                end
            end
            CLS_BRANCH: begin
                // Bias toward operands that sit on the compare boundaries.
                case ($urandom_range(0, 3))
                    0:       ins.operand_b = ins.operand_a;
                    1:       ins.operand_b = ins.operand_a ^ 32'h8000_0000;
                    2:       ins.operand_b = ins.operand_a + 32'd1;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return ins;
    endfunction

    // Optionally idles the instruction channel, then holds the beat until taken.
    task automatic issue_instr(t_in_item ins);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        instr_ch.valid      <= 1'b1;
        instr_ch.op_class   <= ins.op_class;
        instr_ch.funct3     <= ins.funct3;
        instr_ch.funct7     <= ins.funct7;
        instr_ch.operand_a  <= ins.operand_a;
        instr_ch.operand_b  <= ins.operand_b;
        instr_ch.immediate  <= ins.immediate;
        instr_ch.dest_reg   <= ins.dest_reg;
        instr_ch.instr_addr <= ins.instr_addr;
        @(posedge i_clk);
        while (!instr_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    // Result side: random stall bursts unless the run is in a quiet stretch.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet || $urandom_range(0, 99) >= idle_pct) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_in_item directed_list[$];
        int       n_directed;
        instr_ch.valid      <= 1'b0;
        instr_ch.op_class   <= CLS_RTYPE;
        instr_ch.funct3     <= F3_ADD;
        instr_ch.funct7     <= '0;
        instr_ch.operand_a  <= '0;
        instr_ch.operand_b  <= '0;
        instr_ch.immediate  <= '0;
        instr_ch.dest_reg   <= '0;
        instr_ch.instr_addr <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_list.push_back(make_instr(CLS_RTYPE, F3_ADD, '0, '1, 32'd1, '0, 5'd31, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_ADD, F7_ALT, '0, 32'd1, '0, 5'd1, '1));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_SLL, 7'h7f, '1, 32'd31, '0, 5'd2, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_SLT, '0, 32'h8000_0000, 32'h7fff_ffff,
                                           '0, 5'd3, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_SLTU, '0, '0, '1, '0, 5'd4, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_XOR, '0, 32'haaaa_5555, '1,
                                           '0, 5'd5, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_SR, 7'h7f, 32'h8000_0000, 32'd31,
                                           '0, 5'd6, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_SR, F7_ALT, 32'h8000_0000, 32'd31,
                                           '0, 5'd7, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_OR, '0, 32'h0f0f_0f0f, 32'hf0f0_0000,
                                           '0, 5'd8, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_AND, '0, '1, 32'h1234_5678,
                                           '0, 5'd9, '0));
        directed_list.push_back(make_instr(CLS_ITYPE, F3_SR, '0, 32'hf000_0000, 32'h0000_0404,
                                           '0, 5'd10, '0));
        directed_list.push_back(make_instr(CLS_ITYPE, F3_SR, F7_ALT, 32'hf000_0000, 32'd4,
                                           '0, 5'd11, '0));
        directed_list.push_back(make_instr(CLS_ITYPE, F3_ADD, F7_ALT, 32'd5, 32'd3,
                                           '0, 5'd12, '0));
        directed_list.push_back(make_instr(CLS_LOAD, F3_ADD, '0, '1, '1, '1, 5'd13, '1));
        directed_list.push_back(make_instr(CLS_STORE, F3_SLT, '0, '1, '1, '1, 5'd14, '1));
        directed_list.push_back(make_instr(CLS_BRANCH, F3_BEQ, '0, 32'd7, 32'd7, 32'hffff_fff0,
                                           5'd15, 32'hffff_fffc));
        directed_list.push_back(make_instr(CLS_BRANCH, F3_BNE, '0, 32'd7, 32'd7, 32'd16,
                                           5'd16, 32'h100));
        directed_list.push_back(make_instr(CLS_BRANCH, F3_BLT, '0, '1, '0, 32'd8,
                                           5'd17, 32'h200));
        directed_list.push_back(make_instr(CLS_BRANCH, F3_BGE, '0, 32'h7fff_ffff,
                                           32'h8000_0000, 32'h7fff_fffc, 5'd18, 32'h8000_0000));
        directed_list.push_back(make_instr(CLS_BRANCH, F3_BR_NONE, '0, '0, '0, 32'd4,
                                           5'd19, 32'h300));
        directed_list.push_back(make_instr(CLS_BRANCH, F3_BGEU, '0, '1, '0, 32'd4,
                                           5'd20, 32'h300));
        directed_list.push_back(make_instr(CLS_JAL, F3_ADD, '0, '0, '0, '0, 5'd21,
                                           32'hffff_fffc));
        directed_list.push_back(make_instr(CLS_JALR, F3_ADD, '0, '1, '1, '1, '0, 32'h1000));
        directed_list.push_back(make_instr(CLS_LUI, F3_ADD, '0, '0, '0, 32'hffff_f000,
                                           '0, '0));
        directed_list.push_back(make_instr(CLS_RTYPE, F3_ADD, '0, 32'd3, 32'd4, '0, '0, '0));
        n_directed = directed_list.size();

        foreach (directed_list[k]) begin
            issue_instr(directed_list[k]);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // Change the idle pressure every few hundred beats; the tail runs flat out.
            if (i % 250 == 0) begin
                case ($urandom_range(0, 3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 5;
                    2:       idle_pct = 25;
                    default: idle_pct = 60;
                endcase
            end
            if (i == N_RANDOM - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            issue_instr(random_instr());
        end
        instr_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Issued %0d instructions (%0d directed) over all op classes and funct3 codes,",
                 sent_count, n_directed);
        $display("compared %0d results (%0d taken branches) with idle bursts on both sides.",
                 checked, taken);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/rv32exab_pkg.sv
rtl/rv32exab_if.sv
rtl/rv32exab_core.sv
rtl/rv32_execute_alu_branch_unit.sv
sim/rv32exab_checker.sv
sim/testbench.sv
